/* hw/rtl/psf_pkg.sv */
package psf_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned CAP_W  = 12;
  localparam int unsigned FILL_W = 5;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_CLEAR = 2'd2
  } psf_req_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_CAP    = 2'd3
  } psf_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_STREAM
  } psf_state_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;
    logic [CAP_W-1:0]  dest_capacity;
  } psf_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] out_byte;
    logic              byte_valid;
    logic              out_last;
    logic [1:0]        status;
    logic [LEN_W-1:0]  packet_length;
    logic [FILL_W-1:0] fill_level;
  } psf_out_t;

  typedef struct packed {
    logic     load;
    psf_out_t beat;
  } psf_res_t;

endpackage

/* hw/rtl/packet_slot_fifo_top.sv */
// Channel | Direction | Handshake             | Beat
// in      | input     | in_valid_i/in_stall_o | psf_in_t: push byte, pop request or clear
// out     | output    | out_valid_o/out_stall_i | psf_out_t: packet byte or status
//
// Push byte and clear: a status beat follows on the last byte or clear.
// Pop: accept and read the slot length memory, then check capacity, then one byte per
// cycle from the byte memory read port while the output is free; a refused pop ends at the check.
// Output stalls hold the controller; a new beat is taken once the output register frees.
// Reset clears state, pointers, count and the partial packet; slot contents are undefined until written.
module packet_slot_fifo_top import psf_pkg::*; #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned SLOT_BYTES = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  psf_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output psf_out_t out_data_o
);

  localparam int unsigned SW = $clog2(DEPTH);
  localparam int unsigned AW = $clog2(DEPTH * SLOT_BYTES);

  psf_res_t         res;
  logic             out_valid_q;
  psf_out_t         out_data_q;
  logic             out_free;

  logic             bm_we;
  logic [AW-1:0]    bm_waddr, bm_raddr;
  logic [DATA_W-1:0] bm_wdata, bm_rdata;
  logic             lm_we;
  logic [SW-1:0]    lm_waddr, lm_raddr;
  logic [LEN_W-1:0] lm_wdata, lm_rdata;

  assign out_free = !out_valid_q || !out_stall_i;

  psf_ctrl #(
    .DEPTH      (DEPTH),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .out_free_i (out_free),
    .in_stall_o (in_stall_o),
    .res_o      (res),
    .bm_we_o    (bm_we),
    .bm_waddr_o (bm_waddr),
    .bm_wdata_o (bm_wdata),
    .bm_raddr_o (bm_raddr),
    .bm_rdata_i (bm_rdata),
    .lm_we_o    (lm_we),
    .lm_waddr_o (lm_waddr),
    .lm_wdata_o (lm_wdata),
    .lm_raddr_o (lm_raddr),
    .lm_rdata_i (lm_rdata)
  );

  psf_ram #(
    .WORDS (DEPTH * SLOT_BYTES),
    .WIDTH (DATA_W)
  ) u_byte_mem (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .raddr_i (bm_raddr),
    .rdata_o (bm_rdata)
  );

  psf_ram #(
    .WORDS (DEPTH),
    .WIDTH (LEN_W)
  ) u_len_mem (
    .clk_i   (clk_i),
    .we_i    (lm_we),
    .waddr_i (lm_waddr),
    .wdata_i (lm_wdata),
    .raddr_i (lm_raddr),
    .rdata_o (lm_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.load) begin
      out_data_q <= res.beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_accept_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> (!out_valid_o || !out_stall_i))
    else $error("input beat taken while output register blocked");

  a_data_beat_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.byte_valid) |-> (out_data_o.status == ST_OK))
    else $error("data beat carries failure status");

  a_status_beat_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.byte_valid) |->
      (out_data_o.out_byte == '0 && out_data_o.out_last))
    else $error("malformed status beat");

  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.req_type == REQ_CLEAR) |=>
      (out_valid_o && out_data_o.fill_level == '0 && out_data_o.status == ST_OK))
    else $error("clear not answered by empty status beat");

endmodule

/* hw/rtl/psf_ram.sv */
module psf_ram #(
  parameter int unsigned WORDS = 16,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(WORDS)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(WORDS)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [WORDS];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/psf_ctrl.sv */
module psf_ctrl import psf_pkg::*; #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned SLOT_BYTES = 64
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  input  psf_in_t                                  in_data_i,
  input  logic                                     out_free_i,
  output logic                                     in_stall_o,
  output psf_res_t                                 res_o,
  output logic                                     bm_we_o,
  output logic [$clog2(DEPTH*SLOT_BYTES)-1:0]      bm_waddr_o,
  output logic [DATA_W-1:0]                        bm_wdata_o,
  output logic [$clog2(DEPTH*SLOT_BYTES)-1:0]      bm_raddr_o,
  input  logic [DATA_W-1:0]                        bm_rdata_i,
  output logic                                     lm_we_o,
  output logic [$clog2(DEPTH)-1:0]                 lm_waddr_o,
  output logic [LEN_W-1:0]                         lm_wdata_o,
  output logic [$clog2(DEPTH)-1:0]                 lm_raddr_o,
  input  logic [LEN_W-1:0]                         lm_rdata_i
);

  localparam int unsigned SW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH * SLOT_BYTES);
  localparam int unsigned IW = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;

  psf_state_e       state_q, state_d;
  logic [SW-1:0]    ws_q, ws_d, rs_q, rs_d;
  logic [CW-1:0]    count_q, count_d;
  logic [LEN_W-1:0] inc_len_q, inc_len_d;
  logic             inc_rej_q, inc_rej_d;
  logic [CAP_W-1:0] cap_q, cap_d;
  logic [IW-1:0]    idx_q, idx_d;

  logic             accept;
  logic             reject;
  logic [LEN_W-1:0] len_next;
  logic             idx_last;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == SW'(DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  assign accept     = in_valid_i && (state_q == S_IDLE) && out_free_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free_i);
  assign reject     = (count_q == CW'(DEPTH)) || (inc_len_q >= LEN_W'(SLOT_BYTES)) ||
                      inc_rej_q;
  assign len_next   = inc_len_q + 1'b1;
  assign idx_last   = (LEN_W'(idx_q) + 1'b1) == lm_rdata_i;

  assign bm_waddr_o = AW'(AW'(ws_q) * AW'(SLOT_BYTES)) + AW'(inc_len_q);
  assign bm_wdata_o = in_data_i.data_byte;
  assign lm_waddr_o = ws_q;
  assign lm_wdata_o = len_next;
  assign lm_raddr_o = rs_q;

  always_comb begin
    state_d   = state_q;
    ws_d      = ws_q;
    rs_d      = rs_q;
    count_d   = count_q;
    inc_len_d = inc_len_q;
    inc_rej_d = inc_rej_q;
    cap_d     = cap_q;
    idx_d     = idx_q;
    bm_we_o   = 1'b0;
    lm_we_o   = 1'b0;

    res_o                    = '0;
    res_o.beat.out_last      = 1'b1;
    res_o.beat.status        = ST_OK;
    res_o.beat.fill_level    = FILL_W'(count_q);

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_data_i.req_type)
            REQ_PUSH: begin
              if (reject) begin
                inc_rej_d = 1'b1;
              end else begin
                bm_we_o   = 1'b1;
                inc_len_d = len_next;
              end
              if (in_data_i.last_byte) begin
                res_o.load = 1'b1;
                if (reject) begin
                  res_o.beat.status = ST_REJECT;
                end else begin
                  lm_we_o                  = 1'b1;
                  ws_d                     = slot_inc(ws_q);
                  count_d                  = count_q + 1'b1;
                  res_o.beat.packet_length = len_next;
                  res_o.beat.fill_level    = FILL_W'(count_q + 1'b1);
                end
                inc_len_d = '0;
                inc_rej_d = 1'b0;
              end
            end
            REQ_POP: begin
              cap_d = in_data_i.dest_capacity;
              if (count_q == '0) begin
                res_o.load        = 1'b1;
                res_o.beat.status = ST_EMPTY;
              end else begin
                state_d = S_CHECK;
              end
            end
            REQ_CLEAR: begin
              ws_d                  = '0;
              rs_d                  = '0;
              count_d               = '0;
              inc_len_d             = '0;
              inc_rej_d             = 1'b0;
              res_o.load            = 1'b1;
              res_o.beat.fill_level = '0;
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        if (out_free_i) begin
          if ((cap_q == '0) || (cap_q < CAP_W'(lm_rdata_i)) || (lm_rdata_i == '0)) begin
            res_o.load               = 1'b1;
            res_o.beat.status        = ST_CAP;
            res_o.beat.packet_length = lm_rdata_i;
            state_d                  = S_IDLE;
          end else begin
            count_d = count_q - 1'b1;
            idx_d   = '0;
            state_d = S_STREAM;
          end
        end
      end
      S_STREAM: begin
        if (out_free_i) begin
          res_o.load               = 1'b1;
          res_o.beat.out_byte      = bm_rdata_i;
          res_o.beat.byte_valid    = 1'b1;
          res_o.beat.out_last      = idx_last;
          res_o.beat.packet_length = lm_rdata_i;
          if (idx_last) begin
            rs_d    = slot_inc(rs_q);
            idx_d   = '0;
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    // read address follows the next index so the read data lines up with idx_q
    bm_raddr_o = AW'(AW'(rs_q) * AW'(SLOT_BYTES)) + AW'(idx_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ws_q      <= '0;
      rs_q      <= '0;
      count_q   <= '0;
      inc_len_q <= '0;
      inc_rej_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      state_q   <= state_d;
      ws_q      <= ws_d;
      rs_q      <= rs_d;
      count_q   <= count_d;
      inc_len_q <= inc_len_d;
      inc_rej_q <= inc_rej_d;
      idx_q     <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cap_q <= cap_d;
  end

endmodule
